FILE: hdl/wgbs_pkg.sv
// Shared types and constants for the wrapped grid bilinear sampler.
package wgbs_pkg;

    typedef enum logic [0:0] {
        CMD_WRITE = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    localparam int COORD_W          = 32;
    localparam int COORD_FRAC       = 8;
    localparam int HEIGHT_W         = 16;
    localparam int INDEX_W          = 12;
    localparam int SHIFT_W          = 4;
    localparam int PIPE_DEPTH       = 8;
    localparam int DEF_GRID_CELLS   = 64;
    localparam int DEF_FRAC_BITS    = 8;
    localparam logic [SHIFT_W-1:0] CELL_SHIFT_RESET = 4'd4;

endpackage

FILE: hdl/wgbs_if.sv
// Request and response channel interfaces for the sampler.
interface wgbs_in_if import wgbs_pkg::*; ();
    logic                        valid;
    logic                        ready;
    cmd_t                        cmd;
    logic signed [COORD_W-1:0]   x_coord;
    logic signed [COORD_W-1:0]   y_coord;
    logic [INDEX_W-1:0]          cell_index;
    logic signed [HEIGHT_W-1:0]  height_value;

    modport source (output valid, cmd, x_coord, y_coord, cell_index, height_value,
                    input ready);
    modport sink   (input valid, cmd, x_coord, y_coord, cell_index, height_value,
                    output ready);
endinterface

interface wgbs_out_if import wgbs_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic signed [HEIGHT_W-1:0]  height;

    modport source (output valid, height, input ready);
    modport sink   (input valid, height, output ready);
endinterface

FILE: hdl/wgbs_coord_wrap.sv
// Four-stage coordinate wrap: cell index, next cell and fraction of one axis.
module wgbs_coord_wrap import wgbs_pkg::*; #(
    parameter int GRID_CELLS = DEF_GRID_CELLS,
    parameter int FRAC_BITS  = DEF_FRAC_BITS,
    parameter int CW         = $clog2(GRID_CELLS)
) (
    input  logic                      clk,
    input  logic                      en,
    input  logic signed [COORD_W-1:0] coord,
    input  logic [SHIFT_W-1:0]        cell_shift,
    output logic [CW-1:0]             cell_idx,
    output logic [CW-1:0]             cell_next,
    output logic [FRAC_BITS-1:0]      frac
);

    localparam int SW = CW + 11;
    localparam int K  = SW + CW;
    localparam int MW = SW + CW;
    localparam longint unsigned GL  = longint'(GRID_CELLS);
    localparam longint unsigned R8  = (64'd1 << 8) % GL;
    localparam longint unsigned R16 = (64'd1 << 16) % GL;
    localparam longint unsigned R24 = (64'd1 << 24) % GL;
    localparam longint unsigned C31 = (64'd1 << 31) % GL;
    localparam longint unsigned BIAS = GL - C31;
    localparam longint unsigned RECIP = ((64'd1 << K) + GL - 64'd1) / GL;

    // stage A: arithmetic shift down to cell units, fraction
    logic [4:0]                pos;
    logic signed [COORD_W-1:0] q;
    logic [COORD_W-1:0]        mask;
    logic [COORD_W-1:0]        fw;
    logic [COORD_W-1:0]        fs;
    logic signed [COORD_W-1:0] q_a_reg;
    logic [FRAC_BITS-1:0]      frac_a_reg;

    always_comb
    begin
        pos  = 5'(cell_shift) + 5'(COORD_FRAC);
        q    = coord >>> pos;
        mask = (32'd1 << pos) - 32'd1;
        fw   = $unsigned(coord) & mask;
        if (pos >= 5'(FRAC_BITS))
        begin
            fs = fw >> (pos - 5'(FRAC_BITS));
        end
        else
        begin
            fs = fw << (5'(FRAC_BITS) - pos);
        end
    end

    // stage B: fold bytes to a small residue-equivalent sum (offset binary)
    logic [COORD_W-1:0]   u;
    logic [SW-1:0]        s_next;
    logic [SW-1:0]        s_b_reg;
    logic [FRAC_BITS-1:0] frac_b_reg;

    always_comb
    begin
        u      = $unsigned(q_a_reg) ^ 32'h8000_0000;
        s_next = SW'(u[7:0])
               + SW'(u[15:8])  * SW'(R8)
               + SW'(u[23:16]) * SW'(R16)
               + SW'(u[31:24]) * SW'(R24)
               + SW'(BIAS);
    end

    // stage C: quotient by reciprocal multiply
    logic [SW+MW-1:0]     prod;
    logic [SW-1:0]        qh_c_reg;
    logic [SW-1:0]        s_c_reg;
    logic [FRAC_BITS-1:0] frac_c_reg;

    assign prod = (SW+MW)'(s_b_reg) * (SW+MW)'(RECIP);

    // stage D: remainder
    logic [SW+CW:0]       qg;
    logic [SW+CW:0]       rem;
    logic [CW-1:0]        r;
    logic [CW-1:0]        cell_reg;
    logic [CW-1:0]        cell_next_reg;
    logic [FRAC_BITS-1:0] frac_d_reg;

    always_comb
    begin
        qg  = (SW+CW+1)'(qh_c_reg) * (SW+CW+1)'(GL);
        rem = (SW+CW+1)'(s_c_reg) - qg;
        r   = rem[CW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_a_reg       <= q;
            frac_a_reg    <= fs[FRAC_BITS-1:0];
            s_b_reg       <= s_next;
            frac_b_reg    <= frac_a_reg;
            qh_c_reg      <= prod[K +: SW];
            s_c_reg       <= s_b_reg;
            frac_c_reg    <= frac_b_reg;
            cell_reg      <= r;
            cell_next_reg <= (r == CW'(GRID_CELLS - 1)) ? '0 : r + CW'(1);
            frac_d_reg    <= frac_c_reg;
        end
    end

    assign cell_idx  = cell_reg;
    assign cell_next = cell_next_reg;
    assign frac      = frac_d_reg;

endmodule

FILE: hdl/wgbs_grid_ram.sv
// One copy of the height grid: one write port, one registered read port.
module wgbs_grid_ram import wgbs_pkg::*; #(
    parameter int DEPTH = DEF_GRID_CELLS * DEF_GRID_CELLS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                       clk,
    input  logic                       en,
    input  logic                       we,
    input  logic [AW-1:0]              waddr,
    input  logic signed [HEIGHT_W-1:0] wdata,
    input  logic [AW-1:0]              raddr,
    output logic signed [HEIGHT_W-1:0] rdata
);

    logic signed [HEIGHT_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[waddr] <= wdata;
            end
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hdl/wgbs_blend.sv
// Two-stage bilinear blend: row lerps, then the column lerp.
module wgbs_blend import wgbs_pkg::*; #(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                       clk,
    input  logic                       en,
    input  logic signed [HEIGHT_W-1:0] s00,
    input  logic signed [HEIGHT_W-1:0] s01,
    input  logic signed [HEIGHT_W-1:0] s10,
    input  logic signed [HEIGHT_W-1:0] s11,
    input  logic [FRAC_BITS-1:0]       fx,
    input  logic [FRAC_BITS-1:0]       fy,
    output logic signed [HEIGHT_W-1:0] height
);

    localparam int DW = HEIGHT_W + 1;
    localparam int PW = DW + FRAC_BITS + 1;

    // a + floor((b - a) * f / 2^FRAC_BITS); result stays between a and b
    function automatic logic signed [HEIGHT_W-1:0] lerp(
        input logic signed [HEIGHT_W-1:0] a,
        input logic signed [HEIGHT_W-1:0] b,
        input logic [FRAC_BITS-1:0]       f
    );
        logic signed [DW-1:0] diff;
        logic signed [PW-1:0] prod;
        logic signed [PW-1:0] sh;
        logic signed [DW-1:0] sum;
        diff = DW'(b) - DW'(a);
        prod = PW'(diff) * $signed({1'b0, f});
        sh   = prod >>> FRAC_BITS;
        sum  = DW'(a) + sh[DW-1:0];
        return sum[HEIGHT_W-1:0];
    endfunction

    logic signed [HEIGHT_W-1:0] p0_reg;
    logic signed [HEIGHT_W-1:0] p1_reg;
    logic [FRAC_BITS-1:0]       fy_reg;
    logic signed [HEIGHT_W-1:0] h_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg <= lerp(s00, s01, fx);
            p1_reg <= lerp(s10, s11, fx);
            fy_reg <= fy;
            h_reg  <= lerp(p0_reg, p1_reg, fy_reg);
        end
    end

    assign height = h_reg;

endmodule

FILE: hdl/wrapped_grid_bilinear_sampler.sv
// Top level of the wrapped grid bilinear sampler.
//
// req carries write and query beats (valid/ready); rsp returns one height
// beat per query and nothing for a write. cfg_we/cfg_data load cell_shift,
// the log2 of the cell size in world units; write it only while idle.
// Each beat runs through an eight-stage pipeline: four stages wrap the
// coordinates (shift, byte fold, reciprocal multiply, remainder), one forms
// the four corner addresses, one reads four grid copies, two blend.
// One beat is accepted per cycle while rsp does not stall. Writes update
// all grid copies at the read stage, so every query sees exactly the
// writes accepted before it. Reset clears the valid bits and sets
// cell_shift to 4; grid contents are undefined until written. When rsp
// stalls with a result waiting, the whole pipeline holds and req.ready
// drops; nothing is lost or repeated.
module wrapped_grid_bilinear_sampler import wgbs_pkg::*; #(
    parameter int GRID_CELLS = DEF_GRID_CELLS,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [SHIFT_W-1:0]  cfg_data,
    wgbs_in_if.sink             req,
    wgbs_out_if.source          rsp
);

    localparam int CW    = $clog2(GRID_CELLS);
    localparam int DEPTH = GRID_CELLS * GRID_CELLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int WS    = 5;

    logic [SHIFT_W-1:0] cell_shift_reg;
    logic               adv;
    logic [PIPE_DEPTH:1] vld_reg;

    cmd_t                       cmd_reg   [1:WS];
    logic [INDEX_W-1:0]         widx_reg  [1:WS-1];
    logic signed [HEIGHT_W-1:0] wdata_reg [1:WS];
    logic [AW-1:0]              waddr5_reg;
    logic                       wok5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_shift_reg <= CELL_SHIFT_RESET;
        end
        else if (cfg_we)
        begin
            cell_shift_reg <= cfg_data;
        end
    end

    assign adv       = !vld_reg[PIPE_DEPTH] || rsp.ready;
    assign req.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg[1] <= req.valid;
            for (int i = 2; i <= PIPE_DEPTH; i++)
            begin
                if (i == WS + 1)
                begin
                    // writes leave the pipeline at the grid stage
                    vld_reg[i] <= vld_reg[i-1] && (cmd_reg[WS] == CMD_QUERY);
                end
                else
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cmd_reg[1]   <= req.cmd;
            widx_reg[1]  <= req.cell_index;
            wdata_reg[1] <= req.height_value;
            for (int i = 2; i <= WS; i++)
            begin
                cmd_reg[i]   <= cmd_reg[i-1];
                wdata_reg[i] <= wdata_reg[i-1];
            end
            for (int i = 2; i < WS; i++)
            begin
                widx_reg[i] <= widx_reg[i-1];
            end
            waddr5_reg <= AW'(widx_reg[WS-1]);
            wok5_reg   <= 32'(widx_reg[WS-1]) < 32'(DEPTH);
        end
    end

    logic [CW-1:0]        gx;
    logic [CW-1:0]        gx1;
    logic [CW-1:0]        gy;
    logic [CW-1:0]        gy1;
    logic [FRAC_BITS-1:0] fx4;
    logic [FRAC_BITS-1:0] fy4;

    wgbs_coord_wrap #(
        .GRID_CELLS (GRID_CELLS),
        .FRAC_BITS  (FRAC_BITS),
        .CW         (CW)
    ) u_wrap_x (
        .clk        (clk),
        .en         (adv),
        .coord      (req.x_coord),
        .cell_shift (cell_shift_reg),
        .cell_idx   (gx),
        .cell_next  (gx1),
        .frac       (fx4)
    );

    wgbs_coord_wrap #(
        .GRID_CELLS (GRID_CELLS),
        .FRAC_BITS  (FRAC_BITS),
        .CW         (CW)
    ) u_wrap_y (
        .clk        (clk),
        .en         (adv),
        .coord      (req.y_coord),
        .cell_shift (cell_shift_reg),
        .cell_idx   (gy),
        .cell_next  (gy1),
        .frac       (fy4)
    );

    // corner addresses: s00, s01, s10, s11
    logic [AW-1:0]        raddr_reg [4];
    logic [FRAC_BITS-1:0] fx5_reg;
    logic [FRAC_BITS-1:0] fy5_reg;
    logic [FRAC_BITS-1:0] fx6_reg;
    logic [FRAC_BITS-1:0] fy6_reg;
    logic [AW-1:0]        row0;
    logic [AW-1:0]        row1;

    assign row0 = AW'(gy)  * AW'(GRID_CELLS);
    assign row1 = AW'(gy1) * AW'(GRID_CELLS);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            raddr_reg[0] <= row0 + AW'(gx);
            raddr_reg[1] <= row0 + AW'(gx1);
            raddr_reg[2] <= row1 + AW'(gx);
            raddr_reg[3] <= row1 + AW'(gx1);
            fx5_reg      <= fx4;
            fy5_reg      <= fy4;
            fx6_reg      <= fx5_reg;
            fy6_reg      <= fy5_reg;
        end
    end

    logic                       grid_we;
    logic signed [HEIGHT_W-1:0] corner [4];

    assign grid_we = vld_reg[WS] && (cmd_reg[WS] == CMD_WRITE) && wok5_reg;

    for (genvar g = 0; g < 4; g++)
    begin : g_copy
        wgbs_grid_ram #(
            .DEPTH (DEPTH),
            .AW    (AW)
        ) u_ram (
            .clk   (clk),
            .en    (adv),
            .we    (grid_we),
            .waddr (waddr5_reg),
            .wdata (wdata_reg[WS]),
            .raddr (raddr_reg[g]),
            .rdata (corner[g])
        );
    end

    wgbs_blend #(
        .FRAC_BITS (FRAC_BITS)
    ) u_blend (
        .clk    (clk),
        .en     (adv),
        .s00    (corner[0]),
        .s01    (corner[1]),
        .s10    (corner[2]),
        .s11    (corner[3]),
        .fx     (fx6_reg),
        .fy     (fy6_reg),
        .height (rsp.height)
    );

    assign rsp.valid = vld_reg[PIPE_DEPTH];

endmodule
